// ----- sv/dad_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dad_pkg
// Types, constants and the month-length lookup for the date adder.
// ----------------------------------------------------------------------------
package dad_pkg;

    localparam int DATE_W  = 27;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 16;
    localparam int RECIP_W = 28;

    localparam logic [DATE_W-1:0] DATE_MIN       = 27'd10000000;
    localparam logic [DATE_W-1:0] DATE_MAX       = 27'd99999999;
    localparam logic [DATE_W-1:0] DATE_SATURATED = 27'd99991231;
    localparam logic [YEAR_W-1:0] YEAR_LAST      = 14'd9999;
    localparam logic [YEAR_W-1:0] DIV_YEAR       = 14'd10000;
    localparam logic [YEAR_W-1:0] DIV_HUNDRED    = 14'd100;

    // ceil(2^41 / 10000) is exact for any 27-bit dividend,
    // ceil(2^21 / 100) for any 14-bit dividend
    localparam int                 SHIFT_YEAR    = 41;
    localparam int                 SHIFT_HUNDRED = 21;
    localparam logic [RECIP_W-1:0] RECIP_YEAR    = 28'd219902326;
    localparam logic [RECIP_W-1:0] RECIP_HUNDRED = 28'd20972;

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_APR = 4'd4;
    localparam logic [3:0] MONTH_JUN = 4'd6;
    localparam logic [3:0] MONTH_SEP = 4'd9;
    localparam logic [3:0] MONTH_NOV = 4'd11;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_DIV_Y   = 9'b000000010,
        S_DIV_M   = 9'b000000100,
        S_DIV_L   = 9'b000001000,
        S_CHECK   = 9'b000010000,
        S_STEP    = 9'b000100000,
        S_PACK_Y  = 9'b001000000,
        S_PACK_MD = 9'b010000000,
        S_OUT     = 9'b100000000
    } state_t;

    function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month) inside
            MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = 5'd30;
            MONTH_FEB: len = leap ? 5'd29 : 5'd28;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

endpackage

// ----- sv/dad_divider.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dad_divider
// Divide by 10000 or by 100 through a reciprocal multiply, shared by all
// the decimal splits of the date adder. The dividend is registered, then
// the quotient, then the remainder, with done raised alongside the remainder.
// ----------------------------------------------------------------------------
module dad_divider
    import dad_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              by_year,
    input  logic [DATE_W-1:0] dividend,
    output logic              done,
    output logic [YEAR_W-1:0] quotient,
    output logic [YEAR_W-1:0] remainder
);

    localparam int PROD_W = DATE_W + RECIP_W;

    logic              mul_pend_reg, mul_pend_next;
    logic              rem_pend_reg, rem_pend_next;
    logic              done_reg, done_next;
    logic              year_reg, year_next;
    logic [DATE_W-1:0] dvd_reg, dvd_next;
    logic [YEAR_W-1:0] quot_reg, quot_next;
    logic [YEAR_W-1:0] rem_reg, rem_next;

    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod;
    logic [YEAR_W-1:0]  dvs;
    logic [DATE_W-1:0]  back;

    assign recip = year_reg ? RECIP_YEAR : RECIP_HUNDRED;
    assign prod  = PROD_W'(dvd_reg) * PROD_W'(recip);
    assign dvs   = year_reg ? DIV_YEAR : DIV_HUNDRED;
    assign back  = dvd_reg - DATE_W'(quot_reg) * DATE_W'(dvs);

    always_comb
    begin
        mul_pend_next = start;
        rem_pend_next = mul_pend_reg;
        done_next     = rem_pend_reg;
        year_next     = year_reg;
        dvd_next      = dvd_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;
        if (start)
        begin
            year_next = by_year;
            dvd_next  = dividend;
        end
        if (mul_pend_reg)
        begin
            quot_next = year_reg ? prod[SHIFT_YEAR +: YEAR_W] : prod[SHIFT_HUNDRED +: YEAR_W];
        end
        if (rem_pend_reg)
        begin
            rem_next = back[YEAR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_pend_reg <= 1'b0;
            rem_pend_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            mul_pend_reg <= mul_pend_next;
            rem_pend_reg <= rem_pend_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        year_reg <= year_next;
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

// ----- sv/date_add_days.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// date_add_days
// Adds a day count to a packed YYYYMMDD Gregorian date, a month per step.
// ----------------------------------------------------------------------------
// Sequence per item: three splits in the shared divide unit (year, month and
// day, leap year), one check, one month step per month crossed (at most about
// 2155) plus a final step, then the pack states. An invalid start goes from the check to output.
// One item at a time; the next is taken in the idle state after the result leaves.
// Reset (rst_n, async, active low) returns the sequencer to idle.
module date_add_days
    import dad_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATE_W-1:0] start_date,
    input  logic [15:0]       days_to_add,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATE_W-1:0] result_date,
    output logic              input_invalid,
    output logic              year_overflow
);

    state_t              state_reg, state_next;
    logic [DATE_W-1:0]   date_reg, date_next;
    logic [COUNT_W-1:0]  n_reg, n_next;
    logic [YEAR_W-1:0]   y_reg, y_next;
    logic [6:0]          m_reg, m_next;
    logic [6:0]          d_reg, d_next;
    logic [6:0]          mod100_reg, mod100_next;
    logic [8:0]          mod400_reg, mod400_next;
    logic [DATE_W-1:0]   acc_reg, acc_next;
    logic [DATE_W-1:0]   res_reg, res_next;
    logic                inv_reg, inv_next;
    logic                ovf_reg, ovf_next;

    logic                div_start;
    logic                div_by_year;
    logic [DATE_W-1:0]   div_dividend;
    logic                div_done;
    logic [YEAR_W-1:0]   div_quot;
    logic [YEAR_W-1:0]   div_rem;

    logic                leap;
    logic [4:0]          dim;
    logic [COUNT_W:0]    day_sum;
    logic                bad_date;

    dad_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .by_year  (div_by_year),
        .dividend (div_dividend),
        .done     (div_done),
        .quotient (div_quot),
        .remainder(div_rem)
    );

    assign leap    = (mod400_reg == 9'd0) || ((mod100_reg != 7'd0) && (y_reg[1:0] == 2'd0));
    assign dim     = month_days(m_reg[3:0], leap);
    assign day_sum = {{(COUNT_W-6){1'b0}}, d_reg} + {1'b0, n_reg};

    assign bad_date = (date_reg < DATE_MIN) || (date_reg > DATE_MAX)
                   || (m_reg < 7'd1) || (m_reg > 7'd12)
                   || (d_reg < 7'd1) || (d_reg > {2'b00, dim});

    always_comb
    begin
        state_next   = state_reg;
        date_next    = date_reg;
        n_next       = n_reg;
        y_next       = y_reg;
        m_next       = m_reg;
        d_next       = d_reg;
        mod100_next  = mod100_reg;
        mod400_next  = mod400_reg;
        acc_next     = acc_reg;
        res_next     = res_reg;
        inv_next     = inv_reg;
        ovf_next     = ovf_reg;
        div_start    = 1'b0;
        div_dividend = start_date;
        div_by_year  = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    date_next  = start_date;
                    n_next     = days_to_add;
                    div_start  = 1'b1;
                    state_next = S_DIV_Y;
                end
            end
            S_DIV_Y:
            begin
                if (div_done)
                begin
                    y_next       = div_quot;
                    div_start    = 1'b1;
                    div_dividend = DATE_W'(div_rem);
                    div_by_year  = 1'b0;
                    state_next   = S_DIV_M;
                end
            end
            S_DIV_M:
            begin
                if (div_done)
                begin
                    m_next       = div_quot[6:0];
                    d_next       = div_rem[6:0];
                    div_start    = 1'b1;
                    div_dividend = DATE_W'(y_reg);
                    div_by_year  = 1'b0;
                    state_next   = S_DIV_L;
                end
            end
            S_DIV_L:
            begin
                if (div_done)
                begin
                    // year mod 400 = (year/100 mod 4)*100 + year mod 100
                    mod100_next = div_rem[6:0];
                    mod400_next = 9'(div_quot[1:0]) * 9'd100 + 9'(div_rem[6:0]);
                    state_next  = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (bad_date)
                begin
                    res_next   = date_reg;
                    inv_next   = 1'b1;
                    ovf_next   = 1'b0;
                    state_next = S_OUT;
                end
                else
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (n_reg == '0)
                begin
                    state_next = S_PACK_Y;
                end
                else if (day_sum <= (COUNT_W+1)'(dim))
                begin
                    d_next     = day_sum[6:0];
                    n_next     = '0;
                    state_next = S_PACK_Y;
                end
                else
                begin
                    n_next = n_reg - COUNT_W'(dim - d_reg[4:0] + 5'd1);
                    d_next = 7'd1;
                    if (m_reg == 7'd12)
                    begin
                        m_next = 7'd1;
                        if (y_reg == YEAR_LAST)
                        begin
                            res_next   = DATE_SATURATED;
                            inv_next   = 1'b0;
                            ovf_next   = 1'b1;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            y_next      = y_reg + 1'b1;
                            mod100_next = (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 1'b1;
                            mod400_next = (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        m_next = m_reg + 1'b1;
                    end
                end
            end
            S_PACK_Y:
            begin
                acc_next   = DATE_W'(y_reg) * DATE_W'(DIV_YEAR);
                state_next = S_PACK_MD;
            end
            S_PACK_MD:
            begin
                res_next   = acc_reg + DATE_W'(m_reg) * DATE_W'(DIV_HUNDRED) + DATE_W'(d_reg);
                inv_next   = 1'b0;
                ovf_next   = 1'b0;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        date_reg   <= date_next;
        n_reg      <= n_next;
        y_reg      <= y_next;
        m_reg      <= m_next;
        d_reg      <= d_next;
        mod100_reg <= mod100_next;
        mod400_reg <= mod400_next;
        acc_reg    <= acc_next;
        res_reg    <= res_next;
        inv_reg    <= inv_next;
        ovf_reg    <= ovf_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign result_date   = res_reg;
    assign input_invalid = inv_reg;
    assign year_overflow = ovf_reg;

endmodule
